[src/binary_min_heap_priority_queue_macros.svh]
// Assertion macros shared by the heap queue checker.
`ifndef BINARY_MIN_HEAP_PRIORITY_QUEUE_MACROS_SVH
`define BINARY_MIN_HEAP_PRIORITY_QUEUE_MACROS_SVH

// Check an implication on every clock edge outside reset.
`define BMH_ASSERT_IMPL(label, clk, rst, cond, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// Check a signal that must hold while a stall lasts.
`define BMH_ASSERT_HOLD(label, clk, rst, vld, rdy, sig, msg) \
   label: assert property (@(posedge clk) disable iff (rst) \
      (vld && !rdy) |=> $stable(sig)) else $error(msg);

`endif

[src/bmh_pkg.sv]
// Shared types and codes of the heap queue.
package bmh_pkg;

   localparam logic [1:0] MODE_INSERT = 2'd0;
   localparam logic [1:0] MODE_REMOVE = 2'd1;
   localparam logic [1:0] MODE_PEEK   = 2'd2;

   localparam logic [1:0] STATUS_OK    = 2'd0;
   localparam logic [1:0] STATUS_FULL  = 2'd1;
   localparam logic [1:0] STATUS_EMPTY = 2'd2;

   localparam int CAP_WIDTH = 9;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_UP_READ,
      ST_UP_WAIT,
      ST_UP_CMP,
      ST_DN_READ,
      ST_DN_WAIT,
      ST_DN_CMP,
      ST_DN_SWAP,
      ST_RESP
   } ctrl_state_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic load_item;      // latch the request
      logic write_item;     // latch the item, set cursor to count position (insert)
      logic up_read;        // read parent of the cursor
      logic up_swap;        // move parent down, step cursor up
      logic up_place;       // write the moving entry at the cursor
      logic rm_start;       // start removal: fetch last and root
      logic dn_read;        // read both children of the cursor
      logic dn_swap;        // move child up, step cursor down
      logic dn_place;       // write moving entry at cursor
      logic set_result;     // load the result register
      logic [1:0] status;
   } ctrl_cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic [1:0] mode;
      logic full;
      logic empty;
      logic up_at_root;     // cursor is the root
      logic up_go;          // parent strictly greater
      logic dn_leaf;        // no left child
      logic dn_go;          // moving key strictly greater than chosen child
   } dp_stat_type;

endpackage

[src/bmh_ctrl.sv]
// Controller state machine of the heap queue.
module bmh_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   input  bmh_pkg::dp_stat_type  stat,
   output bmh_pkg::ctrl_cmd_type cmd
);
   import bmh_pkg::*;

   ctrl_state_type state_ff, state_in;
   logic           rsp_valid_ff, rsp_valid_in;

   // Hold state and the result flag.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign req_ready = (state_ff == ST_IDLE) && (!rsp_valid_ff || rsp_ready);

   // Sequence one operation; result goes out through the result register.
   always_comb begin
      state_in     = state_ff;
      cmd          = '0;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid && req_ready) begin
               cmd.load_item = 1'b1;
               state_in = ST_RESP;
               if (stat.mode == MODE_INSERT) begin
                  if (stat.full) begin
                     cmd.status = STATUS_FULL;
                  end else begin
                     cmd.write_item = 1'b1;
                     state_in = ST_UP_READ;
                  end
               end else if (stat.mode == MODE_REMOVE || stat.mode == MODE_PEEK) begin
                  if (stat.empty) begin
                     cmd.status = STATUS_EMPTY;
                  end else if (stat.mode == MODE_REMOVE) begin
                     cmd.rm_start = 1'b1;
                     state_in = ST_DN_READ;
                  end
               end
               if (state_in == ST_RESP) begin
                  cmd.set_result = 1'b1;
                  rsp_valid_in   = 1'b1;
                  state_in       = ST_IDLE;
               end
            end
         end
         ST_UP_READ: begin
            if (stat.up_at_root) begin
               cmd.up_place = 1'b1;
               state_in = ST_RESP;
            end else begin
               cmd.up_read = 1'b1;
               state_in = ST_UP_WAIT;
            end
         end
         // Keep the parent address so the read data stays in place.
         ST_UP_WAIT: begin
            cmd.up_read = 1'b1;
            state_in = ST_UP_CMP;
         end
         ST_UP_CMP: begin
            if (stat.up_go) begin
               cmd.up_swap = 1'b1;
               state_in = ST_UP_READ;
            end else begin
               cmd.up_place = 1'b1;
               state_in = ST_RESP;
            end
         end
         ST_DN_READ: begin
            if (stat.dn_leaf) begin
               cmd.dn_place = 1'b1;
               state_in = ST_RESP;
            end else begin
               cmd.dn_read = 1'b1;
               state_in = ST_DN_WAIT;
            end
         end
         ST_DN_WAIT: state_in = ST_DN_CMP;
         ST_DN_CMP: begin
            if (stat.dn_go) begin
               cmd.dn_swap = 1'b1;
               state_in = ST_DN_SWAP;
            end else begin
               cmd.dn_place = 1'b1;
               state_in = ST_RESP;
            end
         end
         ST_DN_SWAP: state_in = ST_DN_READ;
         ST_RESP: begin
            cmd.set_result = 1'b1;
            cmd.status     = STATUS_OK;
            rsp_valid_in   = 1'b1;
            state_in       = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

endmodule

[src/bmh_dp.sv]
// Datapath of the heap queue: entry memories, cursor, count and result.
module bmh_dp #(
   parameter int DEPTH         = 256,
   parameter int KEY_WIDTH     = 32,
   parameter int PAYLOAD_WIDTH = 32
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic [1:0]                      req_mode,
   input  logic [KEY_WIDTH-1:0]            req_item_key,
   input  logic [PAYLOAD_WIDTH-1:0]        req_item_payload,
   input  logic                            csr_write_enable,
   input  logic [bmh_pkg::CAP_WIDTH-1:0]   csr_write_data,
   input  bmh_pkg::ctrl_cmd_type           cmd,
   output bmh_pkg::dp_stat_type            stat,
   output logic [1:0]                      rsp_status,
   output logic [KEY_WIDTH-1:0]            rsp_out_key,
   output logic [PAYLOAD_WIDTH-1:0]        rsp_out_payload,
   output logic [bmh_pkg::CAP_WIDTH-1:0]   rsp_count
);
   import bmh_pkg::*;

   localparam int AW = $clog2(DEPTH);
   localparam int CW = $clog2(DEPTH + 1);
   localparam int EW = KEY_WIDTH + PAYLOAD_WIDTH;

   // Key and payload share one word per entry; two ports cover both children.
   logic [EW-1:0] mem_a [DEPTH];
   logic [EW-1:0] mem_b [DEPTH];

   logic [CAP_WIDTH-1:0] cap_ff;
   logic [CW-1:0]        count_ff, count_in;
   logic [CW:0]          pos_ff, pos_in;     // cursor, one bit wider for child math
   logic [EW-1:0]        move_ff, move_in;   // entry being sifted
   logic [1:0]           mode_ff;
   logic [EW-1:0]        rd_a_ff, rd_b_ff;
   logic [EW-1:0]        root_ff;
   logic                 has_right_ff;
   logic                 fetch_ff;           // rm_start read pending

   logic [1:0]           status_ff;
   logic [EW-1:0]        res_ff;
   logic [CW-1:0]        cnt_out_ff;

   logic                 wr_a_en, wr_b_en;
   logic [AW-1:0]        wr_a_addr, rd_a_addr, rd_b_addr;
   logic [EW-1:0]        wr_a_data;
   logic [CW:0]          left_w, right_w, parent_w;
   logic [CW:0]          cap_eff;
   logic                 pick_right;
   logic [EW-1:0]        child_w;

   // Hold the capacity register.
   always_ff @(posedge clock) begin
      if (reset) begin
         cap_ff <= CAP_WIDTH'(256);
      end else if (csr_write_enable) begin
         cap_ff <= csr_write_data;
      end
   end

   assign cap_eff  = ({{(CW+1){1'b0}}, cap_ff} > (CW+1+CAP_WIDTH)'(DEPTH))
                     ? (CW+1)'(DEPTH) : (CW+1)'(cap_ff);
   assign left_w   = (CW+1)'({pos_ff, 1'b1});
   assign right_w  = left_w + (CW+1)'(1);
   assign parent_w = (pos_ff - (CW+1)'(1)) >> 1;

   assign pick_right = has_right_ff &&
                       (rd_a_ff[EW-1 -: KEY_WIDTH] > rd_b_ff[EW-1 -: KEY_WIDTH]);
   assign child_w    = pick_right ? rd_b_ff : rd_a_ff;

   assign stat.mode       = req_mode;
   assign stat.full       = ({1'b0, count_ff} >= cap_eff);
   assign stat.empty      = (count_ff == '0);
   assign stat.up_at_root = (pos_ff == '0);
   assign stat.up_go      = rd_a_ff[EW-1 -: KEY_WIDTH] > move_ff[EW-1 -: KEY_WIDTH];
   assign stat.dn_leaf    = fetch_ff ? ((CW+1)'(1) >= (CW+1)'(count_ff))
                                     : (left_w >= (CW+1)'(count_ff));
   assign stat.dn_go      = move_ff[EW-1 -: KEY_WIDTH] > child_w[EW-1 -: KEY_WIDTH];

   // Select memory write and read addresses.
   always_comb begin
      wr_a_en   = 1'b0;
      wr_a_addr = pos_ff[AW-1:0];
      wr_a_data = move_in;
      rd_a_addr = left_w[AW-1:0];
      rd_b_addr = right_w[AW-1:0];
      if (cmd.up_read) begin
         rd_a_addr = parent_w[AW-1:0];
      end
      if (cmd.rm_start) begin
         rd_a_addr = AW'(count_ff - CW'(1));
         rd_b_addr = '0;
      end
      if (cmd.up_swap) begin
         wr_a_en   = 1'b1;
         wr_a_data = rd_a_ff;
      end
      if (cmd.dn_swap) begin
         wr_a_en   = 1'b1;
         wr_a_data = child_w;
      end
      if (cmd.up_place || cmd.dn_place) begin
         wr_a_en = 1'b1;
      end
      wr_b_en = wr_a_en;
   end

   // Write both copies, read one address from each.
   always_ff @(posedge clock) begin
      if (wr_a_en) mem_a[wr_a_addr] <= wr_a_data;
      if (wr_b_en) mem_b[wr_a_addr] <= wr_a_data;
      rd_a_ff <= mem_a[rd_a_addr];
      rd_b_ff <= mem_b[rd_b_addr];
   end

   // Advance cursor, moving entry and count.
   always_comb begin
      pos_in   = pos_ff;
      move_in  = move_ff;
      count_in = count_ff;
      if (cmd.write_item) begin
         pos_in   = (CW+1)'(count_ff);
         move_in  = {req_item_key, req_item_payload};
         count_in = count_ff + CW'(1);
      end
      // Take the last entry as it arrives from memory.
      if (fetch_ff) move_in = rd_a_ff;
      if (cmd.up_swap) pos_in = parent_w;
      if (cmd.rm_start) begin
         pos_in   = '0;
         count_in = count_ff - CW'(1);
      end
      if (cmd.dn_swap) pos_in = pick_right ? right_w : left_w;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         fetch_ff <= 1'b0;
      end else begin
         count_ff <= count_in;
         fetch_ff <= cmd.rm_start ? 1'b1 : (cmd.dn_read || cmd.dn_place) ? 1'b0 : fetch_ff;
      end
   end

   // Hold operation context; the removal fetch lands in the cycle after rm_start.
   always_ff @(posedge clock) begin
      pos_ff       <= pos_in;
      has_right_ff <= right_w < (CW+1)'(count_ff);
      if (fetch_ff || cmd.load_item || cmd.write_item) begin
         move_ff <= move_in;
      end
      if (cmd.load_item) begin
         mode_ff <= req_mode;
      end
   end

   // Capture the removed root as it comes out of memory; root_rd_ff tracks entry 0 for peek.
   logic fetch_d_ff;
   always_ff @(posedge clock) begin
      if (reset) begin
         fetch_d_ff <= 1'b0;
      end else begin
         fetch_d_ff <= cmd.rm_start;
      end
   end

   logic [EW-1:0] root_rd_ff;
   always_ff @(posedge clock) begin
      root_rd_ff <= mem_a[0];
      if (fetch_d_ff) begin
         root_ff <= rd_b_ff;
      end
   end

   // Load the result register.
   always_ff @(posedge clock) begin
      if (cmd.set_result) begin
         status_ff  <= cmd.status;
         cnt_out_ff <= count_ff;
         if (cmd.load_item) begin
            if (req_mode == MODE_PEEK && cmd.status == STATUS_OK) begin
               res_ff <= root_rd_ff;
            end else begin
               res_ff <= '0;
            end
         end else if (mode_ff == MODE_REMOVE) begin
            res_ff <= root_ff;
         end else begin
            res_ff <= '0;
         end
      end
   end

   assign rsp_status      = status_ff;
   assign rsp_out_key     = res_ff[EW-1 -: KEY_WIDTH];
   assign rsp_out_payload = res_ff[PAYLOAD_WIDTH-1:0];
   assign rsp_count       = CAP_WIDTH'(cnt_out_ff);

endmodule

[src/binary_min_heap_priority_queue.sv]
// Top level of the binary min-heap priority queue.
// Usage:
//   req_* channel carries one operation per item: mode 0 insert
//   (req_item_key, req_item_payload), 1 remove minimum, 2 peek minimum.
//   rsp_* channel returns one item per operation: status, out_key,
//   out_payload and count after the operation.
//   csr_write_enable/csr_write_data set the capacity limit (reset 256),
//   clamped to DEPTH; write only while idle.
// Sequence:
//   Peek, rejected, empty and unused-mode operations: result registered
//   at accept and valid in the cycle after accept.
//   Insert: per level climbed, read the parent, wait, compare and swap;
//   then write the entry at the root or below a parent that is not greater.
//   Remove: fetch the last entry and the root, then per level descended
//   read both children, wait, compare and swap; then write at the stop.
//   Each level costs a memory read, a compare and a write.
//   One operation is in flight at a time.
// Reset empties the queue at once; no clearing pass.
// A stalled result waits in the output register; the next item is taken
// in the cycle the result is accepted.
module binary_min_heap_priority_queue #(
   parameter int DEPTH         = 256,
   parameter int KEY_WIDTH     = 32,
   parameter int PAYLOAD_WIDTH = 32
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic [1:0]                    req_mode,
   input  logic [KEY_WIDTH-1:0]          req_item_key,
   input  logic [PAYLOAD_WIDTH-1:0]      req_item_payload,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic [1:0]                    rsp_status,
   output logic [KEY_WIDTH-1:0]          rsp_out_key,
   output logic [PAYLOAD_WIDTH-1:0]      rsp_out_payload,
   output logic [bmh_pkg::CAP_WIDTH-1:0] rsp_count,
   input  logic                          csr_write_enable,
   input  logic [bmh_pkg::CAP_WIDTH-1:0] csr_write_data
);
   import bmh_pkg::*;

   ctrl_cmd_type cmd;
   dp_stat_type  stat;

   bmh_ctrl u_ctrl (
      .clock, .reset, .req_valid, .req_ready, .rsp_valid, .rsp_ready,
      .stat, .cmd
   );

   bmh_dp #(
      .DEPTH(DEPTH), .KEY_WIDTH(KEY_WIDTH), .PAYLOAD_WIDTH(PAYLOAD_WIDTH)
   ) u_dp (
      .clock, .reset, .req_mode, .req_item_key, .req_item_payload,
      .csr_write_enable, .csr_write_data, .cmd, .stat,
      .rsp_status, .rsp_out_key, .rsp_out_payload, .rsp_count
   );

endmodule

[src/bmh_checker.sv]
// Port-level checker of the heap queue, bound to the top level.
`include "binary_min_heap_priority_queue_macros.svh"
module bmh_checker (
   input logic       clock,
   input logic       reset,
   input logic       req_valid,
   input logic       req_ready,
   input logic       rsp_valid,
   input logic       rsp_ready,
   input logic [1:0] rsp_status,
   input logic [8:0] rsp_count
);
   import bmh_pkg::*;

   `BMH_ASSERT_IMPL(a_one_in_flight, clock, reset, !(rsp_valid && !rsp_ready) || !req_ready, "item accepted while result stalled")
   `BMH_ASSERT_IMPL(a_empty_count, clock, reset, !(rsp_valid && rsp_status == STATUS_EMPTY) || rsp_count == '0, "empty status with entries")
   `BMH_ASSERT_IMPL(a_status_code, clock, reset, !rsp_valid || rsp_status == STATUS_OK || rsp_status == STATUS_FULL || rsp_status == STATUS_EMPTY, "bad status code")
   `BMH_ASSERT_HOLD(a_rsp_hold, clock, reset, rsp_valid, rsp_ready, rsp_count, "result changed while stalled")

endmodule

bind binary_min_heap_priority_queue bmh_checker u_bmh_checker (
   .clock, .reset, .req_valid, .req_ready, .rsp_valid, .rsp_ready,
   .rsp_status, .rsp_count
);

[dv/tb.sv]
// Self-checking testbench for the binary min-heap priority queue.
`timescale 1ns / 1ps

module tb;
   import bmh_pkg::*;

   localparam int DEPTH = 256;
   localparam int LIMIT_CYCLES = 400000;
   localparam logic [1:0] MODE_NONE = 2'd3;

   typedef struct packed {
      logic [1:0]  mode;
      logic [31:0] key;
      logic [31:0] payload;
   } heap_op_type;

   typedef struct packed {
      logic [1:0]  status;
      logic [31:0] key;
      logic [31:0] payload;
      logic [8:0]  count;
   } heap_rsp_type;

   // directed row: op plus optional typed-in expectation
   typedef struct packed {
      heap_op_type  op;
      logic         typed;
      heap_rsp_type want;
   } drow_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   logic [1:0]  req_mode = MODE_INSERT;
   logic [31:0] req_item_key = '0;
   logic [31:0] req_item_payload = '0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic [1:0]  rsp_status;
   logic [31:0] rsp_out_key;
   logic [31:0] rsp_out_payload;
   logic [8:0]  rsp_count;
   logic        csr_write_enable = 1'b0;
   logic [8:0]  csr_write_data = '0;

   binary_min_heap_priority_queue dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_mode(req_mode),
      .req_item_key(req_item_key), .req_item_payload(req_item_payload),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_status(rsp_status),
      .rsp_out_key(rsp_out_key), .rsp_out_payload(rsp_out_payload),
      .rsp_count(rsp_count),
      .csr_write_enable(csr_write_enable), .csr_write_data(csr_write_data)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // predictor state
   logic [31:0] mdl_keys [DEPTH];
   logic [31:0] mdl_pays [DEPTH];
   int          mdl_count;
   logic [8:0]  mdl_cap;

   heap_rsp_type expected_rsps[$];
   int  errors = 0;
   int  cycles = 0;
   int  rsp_seen = 0;
   int  send_idle_pct = 0;
   int  recv_idle_pct = 0;
   int  full_seen = 0;
   int  empty_seen = 0;
   bit  done = 1'b0;

   task automatic report(input string what, input heap_rsp_type got, input heap_rsp_type want);
      errors++;
      $display("ERR %s: got st=%0d k=%h p=%h c=%0d want st=%0d k=%h p=%h c=%0d", what,
               got.status, got.key, got.payload, got.count,
               want.status, want.key, want.payload, want.count);
   endtask

   function automatic void swap_slots(int a, int b);
      logic [31:0] k, p;
      k = mdl_keys[a]; p = mdl_pays[a];
      mdl_keys[a] = mdl_keys[b]; mdl_pays[a] = mdl_pays[b];
      mdl_keys[b] = k; mdl_pays[b] = p;
   endfunction

   // compute the response of one operation and update the shadow heap
   function automatic heap_rsp_type predict_heap(input heap_op_type op);
      heap_rsp_type r;
      int cap, pos, up, lt, rt, pick;
      r = '0;
      cap = (mdl_cap > DEPTH) ? DEPTH : int'(mdl_cap);
      if (op.mode == MODE_INSERT) begin
         if (mdl_count >= cap) begin
            r.status = STATUS_FULL;
         end else begin
            mdl_keys[mdl_count] = op.key;
            mdl_pays[mdl_count] = op.payload;
            pos = mdl_count;
            mdl_count++;
            while (pos > 0) begin
               up = (pos - 1) / 2;
               if (mdl_keys[up] > mdl_keys[pos]) begin
                  swap_slots(up, pos);
                  pos = up;
               end else break;
            end
         end
      end else if (op.mode == MODE_REMOVE || op.mode == MODE_PEEK) begin
         if (mdl_count == 0) begin
            r.status = STATUS_EMPTY;
         end else begin
            r.key = mdl_keys[0];
            r.payload = mdl_pays[0];
            if (op.mode == MODE_REMOVE) begin
               mdl_count--;
               mdl_keys[0] = mdl_keys[mdl_count];
               mdl_pays[0] = mdl_pays[mdl_count];
               pos = 0;
               while (1) begin
                  lt = 2 * pos + 1;
                  rt = lt + 1;
                  if (lt >= mdl_count) break;
                  pick = lt;
                  if (rt < mdl_count && mdl_keys[lt] > mdl_keys[rt]) pick = rt;
                  if (mdl_keys[pos] > mdl_keys[pick]) begin
                     swap_slots(pos, pick);
                     pos = pick;
                  end else break;
               end
            end
         end
      end
      r.count = 9'(mdl_count);
      return r;
   endfunction

   // drive one item and hold it until accepted; valid drops only when idling
   task automatic send_op(input heap_op_type op, input bit typed, input heap_rsp_type want);
      heap_rsp_type p;
      bit idle;
      idle = ($urandom_range(99) < send_idle_pct);
      if (idle) req_valid <= 1'b0;
      while (idle) begin
         @(posedge clock);
         idle = ($urandom_range(99) < send_idle_pct);
      end
      req_valid <= 1'b1;
      req_mode <= op.mode;
      req_item_key <= op.key;
      req_item_payload <= op.payload;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      p = predict_heap(op);
      if (typed && p != want) report("typed row disagrees with predictor", p, want);
      expected_rsps.push_back(typed ? want : p);
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      while (expected_rsps.size() != 0) @(posedge clock);
      repeat (40) @(posedge clock);
   endtask

   task automatic write_cap(input logic [8:0] v);
      csr_write_enable <= 1'b1;
      csr_write_data <= v;
      @(posedge clock);
      csr_write_enable <= 1'b0;
      mdl_cap = v;
   endtask

   function automatic heap_op_type rand_op(input int insert_pct, input int key_span);
      heap_op_type op;
      int pick;
      pick = $urandom_range(99);
      if (pick < insert_pct) op.mode = MODE_INSERT;
      else if (pick < insert_pct + (100 - insert_pct) * 7 / 10) op.mode = MODE_REMOVE;
      else if (pick < 98) op.mode = MODE_PEEK;
      else op.mode = MODE_NONE;
      op.key = (key_span == 0) ? $urandom() : $urandom_range(key_span);
      op.payload = $urandom();
      return op;
   endfunction

   // accept results under random backpressure and compare
   always @(posedge clock) begin
      heap_rsp_type got, want;
      if (!reset) begin
         if (rsp_valid && rsp_ready) begin
            got = {rsp_status, rsp_out_key, rsp_out_payload, rsp_count};
            if (got.status == STATUS_FULL) full_seen++;
            if (got.status == STATUS_EMPTY) empty_seen++;
            rsp_seen++;
            if (expected_rsps.size() == 0) begin
               report("unexpected item", got, '0);
            end else begin
               want = expected_rsps.pop_front();
               if (got.status != want.status) report("status", got, want);
               if (got.key != want.key) report("out_key", got, want);
               if (got.payload != want.payload) report("out_payload", got, want);
               if (got.count != want.count) report("count", got, want);
            end
         end
         rsp_ready <= ($urandom_range(99) >= recv_idle_pct);
      end
   end

   // watchdog
   always @(posedge clock) begin
      cycles++;
      if (cycles > LIMIT_CYCLES && !done) begin
         $display("timeout after %0d cycles", cycles);
         $display("SCOREBOARD MISMATCH");
         $finish;
      end
   end

   function automatic drow_type row(input logic [1:0] m, input logic [31:0] k,
                                    input logic [31:0] p, input logic t,
                                    input heap_rsp_type w);
      drow_type d;
      d.op = {m, k, p};
      d.typed = t;
      d.want = w;
      return d;
   endfunction

   initial begin
      drow_type dir[$];
      heap_op_type op;
      int n, phase, lo;
      mdl_count = 0;
      mdl_cap = 9'd256;
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: empty cases, extremes, ties, mode 3
      dir.push_back(row(MODE_REMOVE, '0, '0, 1, {STATUS_EMPTY, 32'd0, 32'd0, 9'd0}));
      dir.push_back(row(MODE_PEEK, '0, '0, 1, {STATUS_EMPTY, 32'd0, 32'd0, 9'd0}));
      dir.push_back(row(MODE_NONE, '1, '1, 1, {STATUS_OK, 32'd0, 32'd0, 9'd0}));
      dir.push_back(row(MODE_INSERT, '1, '1, 1, {STATUS_OK, 32'd0, 32'd0, 9'd1}));
      dir.push_back(row(MODE_PEEK, '0, '0, 1, {STATUS_OK, 32'hFFFFFFFF, 32'hFFFFFFFF, 9'd1}));
      dir.push_back(row(MODE_INSERT, '0, 32'h5A5A5A5A, 1, {STATUS_OK, 32'd0, 32'd0, 9'd2}));
      dir.push_back(row(MODE_INSERT, 32'd7, 32'h1, 0, '0));
      dir.push_back(row(MODE_INSERT, 32'd7, 32'h2, 0, '0));
      dir.push_back(row(MODE_INSERT, 32'd7, 32'h3, 0, '0));
      dir.push_back(row(MODE_INSERT, 32'd3, 32'hA5A5A5A5, 0, '0));
      dir.push_back(row(MODE_REMOVE, '0, '0, 1, {STATUS_OK, 32'd0, 32'h5A5A5A5A, 9'd5}));
      for (int i = 0; i < 6; i++) dir.push_back(row(MODE_REMOVE, '0, '0, 0, '0));
      foreach (dir[i]) send_op(dir[i].op, dir[i].typed, dir[i].want);
      drain();

      // capacity 2: third insert is rejected
      write_cap(9'd2);
      for (int i = 0; i < 3; i++) send_op({MODE_INSERT, 32'(i), 32'(i)}, 0, '0);
      drain();
      // capacity 0 with entries kept
      write_cap(9'd0);
      send_op({MODE_INSERT, 32'd9, 32'd9}, 1, {STATUS_FULL, 32'd0, 32'd0, 9'd2});
      send_op({MODE_REMOVE, 32'd0, 32'd0}, 0, '0);
      send_op({MODE_REMOVE, 32'd0, 32'd0}, 0, '0);
      drain();

      // random phases: idling pattern times several capacities
      for (phase = 0; phase < 3; phase++) begin
         send_idle_pct = (phase == 0) ? 24 : (phase == 1) ? 66 : 0;
         recv_idle_pct = (phase == 0) ? 66 : (phase == 1) ? 24 : 0;
         case (phase)
            0: write_cap(9'd511);
            1: write_cap(9'd5);
            default: write_cap(9'd256);
         endcase
         n = 0;
         while (n < 560) begin
            // fill, then drain, so the heap reaches both ends
            lo = ((n / 150) % 2 == 0) ? 75 : 25;
            if (phase == 2 && n >= 300 && n < 560) lo = 95;
            op = rand_op(lo, (n % 3 == 0) ? 15 : 0);
            send_op(op, 0, '0);
            n++;
            // stretch of no sender idling, and one full pause
            if (n == 200) drain();
         end
         drain();
      end
      // overflow 256 and drain to empty
      send_idle_pct = 0;
      while (mdl_count < DEPTH) send_op(rand_op(100, 0), 0, '0);
      send_op({MODE_INSERT, 32'd1, 32'd1}, 0, '0);
      while (mdl_count > 0) send_op({MODE_REMOVE, 32'd0, 32'd0}, 0, '0);
      drain();

      done = 1'b1;
      $display("Covered %0d results: %0d full rejects, %0d empty reads,", rsp_seen,
               full_seen, empty_seen);
      $display("capacities 0, 2, 5, 256 and 511, under mixed backpressure.");
      if (errors == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

endmodule

[files.f]
+incdir+src
src/bmh_pkg.sv
src/bmh_ctrl.sv
src/bmh_dp.sv
src/binary_min_heap_priority_queue.sv
src/bmh_checker.sv
dv/tb.sv
